// ----- sv/pixelate_2x2_block_average_defines.svh -----
// ---------------------------------------------------------------------------
// pixelate_2x2_block_average defines
// Assertion macros for the port-level checker pix2avg_checker.
// ---------------------------------------------------------------------------
`ifndef PIXELATE_2X2_BLOCK_AVERAGE_DEFINES_SVH
`define PIXELATE_2X2_BLOCK_AVERAGE_DEFINES_SVH

// same-cycle implication
`define P2A_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define P2A_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pix2avg_pkg.sv -----
// ---------------------------------------------------------------------------
// pix2avg_pkg
// Shared types and constants of the 2x2 block average pixelator.
// ---------------------------------------------------------------------------
package pix2avg_pkg;

    localparam int PIX_W       = 8;
    localparam int SUM_W       = 9;
    localparam int COORD_W     = 9;
    localparam int CFG_W       = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_TOP_LEFT,
        PH_TOP_RIGHT,
        PH_BOT_LEFT,
        PH_BOT_RIGHT
    } t_phase;

    typedef struct packed {
        logic [PIX_W-1:0]   value;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               eof;
    } t_block;

endpackage

// ----- sv/pix2avg_line_mem.sv -----
// ---------------------------------------------------------------------------
// pix2avg_line_mem
// Line buffer of horizontal pair sums, one write and one registered read port.
// ---------------------------------------------------------------------------
module pix2avg_line_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [pix2avg_pkg::SUM_W-1:0] i_wr_data,
    input  logic                          i_rd_en,
    input  logic [AW-1:0]                 i_rd_addr,
    output logic [pix2avg_pkg::SUM_W-1:0] o_rd_data
);

    logic [pix2avg_pkg::SUM_W-1:0] r_mem [DEPTH];
    logic [pix2avg_pkg::SUM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- sv/pix2avg_blk_queue.sv -----
// ---------------------------------------------------------------------------
// pix2avg_blk_queue
// Small queue of finished blocks; expands each block into four result words.
// ---------------------------------------------------------------------------
module pix2avg_blk_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  pix2avg_pkg::t_block             i_blk,
    output logic                            o_full,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [pix2avg_pkg::PIX_W-1:0]   o_value,
    output logic [pix2avg_pkg::COORD_W-1:0] o_out_row,
    output logic [pix2avg_pkg::COORD_W-1:0] o_out_col,
    output logic                            o_last_of_block,
    output logic                            o_end_of_frame
);

    localparam int PW = pix2avg_pkg::QPTR_W;
    localparam int CW = pix2avg_pkg::COORD_W;

    pix2avg_pkg::t_block r_q [pix2avg_pkg::QUEUE_DEPTH];
    logic [PW-1:0]       r_wr_ptr;
    logic [PW-1:0]       r_rd_ptr;
    logic [PW:0]         r_count;
    pix2avg_pkg::t_phase r_phase;
    pix2avg_pkg::t_phase n_phase;

    logic                          r_out_valid;
    logic [pix2avg_pkg::PIX_W-1:0] r_out_value;
    logic [CW-1:0]                 r_out_row;
    logic [CW-1:0]                 r_out_col;
    logic                          r_out_last;
    logic                          r_out_eof;

    logic [CW-1:0]       n_row;
    logic [CW-1:0]       n_col;
    logic                n_last;
    logic                n_eof;
    pix2avg_pkg::t_block head;
    logic                load;
    logic                pop;

    assign head   = r_q[r_rd_ptr];
    assign o_full = (r_count == (PW+1)'(pix2avg_pkg::QUEUE_DEPTH));
    assign load   = (r_count != '0) && (!r_out_valid || !i_stall);
    assign pop    = load && (r_phase == pix2avg_pkg::PH_BOT_RIGHT);

    always_comb begin
        n_phase = r_phase;
        if (load) begin
            case (r_phase)
                pix2avg_pkg::PH_TOP_LEFT:  n_phase = pix2avg_pkg::PH_TOP_RIGHT;
                pix2avg_pkg::PH_TOP_RIGHT: n_phase = pix2avg_pkg::PH_BOT_LEFT;
                pix2avg_pkg::PH_BOT_LEFT:  n_phase = pix2avg_pkg::PH_BOT_RIGHT;
                pix2avg_pkg::PH_BOT_RIGHT: n_phase = pix2avg_pkg::PH_TOP_LEFT;
                default:                   n_phase = pix2avg_pkg::PH_TOP_LEFT;
            endcase
        end
    end

    always_comb begin
        n_row  = head.row;
        n_col  = head.col;
        n_last = 1'b0;
        n_eof  = 1'b0;
        case (r_phase)
            pix2avg_pkg::PH_TOP_LEFT: begin
                n_row = head.row - CW'(1);
                n_col = head.col - CW'(1);
            end
            pix2avg_pkg::PH_TOP_RIGHT: begin
                n_row = head.row - CW'(1);
            end
            pix2avg_pkg::PH_BOT_LEFT: begin
                n_col = head.col - CW'(1);
            end
            pix2avg_pkg::PH_BOT_RIGHT: begin
                n_last = 1'b1;
                n_eof  = head.eof;
            end
            default: begin
                n_row = head.row;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_phase     <= pix2avg_pkg::PH_TOP_LEFT;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + (PW+1)'(1);
                2'b01:   r_count <= r_count - (PW+1)'(1);
                default: r_count <= r_count;
            endcase
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_value <= head.value;
            r_out_row   <= n_row;
            r_out_col   <= n_col;
            r_out_last  <= n_last;
            r_out_eof   <= n_eof;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_value         = r_out_value;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_last_of_block = r_out_last;
    assign o_end_of_frame  = r_out_eof;

endmodule

// ----- sv/pixelate_2x2_block_average.sv -----
// ---------------------------------------------------------------------------
// pixelate_2x2_block_average
// 2x2 average pooling of a raster-order 8-bit grayscale pixel stream.
//
//   channel   handshake                    word
//   --------  ---------------------------  -----------------------------------
//   cfg       i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//   pixel in  i_valid / o_stall            i_pixel
//   result    o_valid / i_stall            o_value, o_out_row, o_out_col,
//                                          o_last_of_block, o_end_of_frame
//
// Even rows take one pixel per cycle while o_stall is low. Each odd-row,
// odd-column pixel makes a block of four result words; the output port sends
// one word per cycle while i_stall is low, so odd rows stall once the
// four-block queue is full. A block passes the r_s1 registers, the queue
// and the output register before its first word leaves. Reset is synchronous;
// the line buffer is not cleared (rows are written before they are read).
// Upstream stalls only when a finished block cannot enter the queue.
// ---------------------------------------------------------------------------
module pixelate_2x2_block_average #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pix2avg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pix2avg_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [pix2avg_pkg::PIX_W-1:0]     i_pixel,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [pix2avg_pkg::PIX_W-1:0]     o_value,
    output logic [pix2avg_pkg::COORD_W-1:0]   o_out_row,
    output logic [pix2avg_pkg::COORD_W-1:0]   o_out_col,
    output logic                              o_last_of_block,
    output logic                              o_end_of_frame
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int LD = MAX_WIDTH / 2;
    localparam int AW = (LD > 1) ? $clog2(LD) : 1;
    localparam int SW = pix2avg_pkg::SUM_W;
    localparam int PXW = pix2avg_pkg::PIX_W;
    localparam int KW = pix2avg_pkg::COORD_W;
    localparam logic [WW-1:0] RST_W = WW'((MAX_WIDTH < 512) ? MAX_WIDTH : 512);
    localparam logic [HW-1:0] RST_H = HW'((MAX_HEIGHT < 512) ? MAX_HEIGHT : 512);

    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [WW-1:0] n_width;
    logic [HW-1:0] n_height;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic [PXW-1:0] r_left;

    logic          r_s1_blk;
    logic [SW-1:0] r_s1_sum;
    logic [KW-1:0] r_s1_row;
    logic [KW-1:0] r_s1_col;
    logic          r_s1_eof;

    logic                cfg_wr;
    logic                cfg_hit;
    logic                acc;
    logic                wr_pair;
    logic                rd_pair;
    logic [SW-1:0]       pair_sum;
    logic [AW-1:0]       line_addr;
    logic [SW-1:0]       above;
    logic [SW:0]         total;
    logic                eof;
    logic                q_full;
    logic                push;
    pix2avg_pkg::t_block blk;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign cfg_hit     = (i_cfg_index == pix2avg_pkg::CFG_FRAME_WIDTH)
                      || (i_cfg_index == pix2avg_pkg::CFG_FRAME_HEIGHT);

    always_comb begin
        if (i_cfg_data < pix2avg_pkg::CFG_W'(2)) begin
            n_width = WW'(2);
        end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
            n_width = WW'(MAX_WIDTH);
        end else begin
            n_width = WW'(i_cfg_data);
        end
    end

    always_comb begin
        if (i_cfg_data < pix2avg_pkg::CFG_W'(2)) begin
            n_height = HW'(2);
        end else if (32'(i_cfg_data) > 32'(MAX_HEIGHT)) begin
            n_height = HW'(MAX_HEIGHT);
        end else begin
            n_height = HW'(i_cfg_data);
        end
    end

    assign o_stall   = r_s1_blk && q_full;
    assign acc       = i_valid && !o_stall;
    assign wr_pair   = acc && r_col[0] && !r_row[0];
    assign rd_pair   = acc && r_col[0] && r_row[0];
    assign pair_sum  = {1'b0, r_left} + {1'b0, i_pixel};
    assign line_addr = AW'(r_col >> 1);
    assign eof       = (HW'(r_row) == ((r_height & ~HW'(1)) - HW'(1)))
                    && (WW'(r_col) == ((r_width & ~WW'(1)) - WW'(1)));

    always_comb begin
        n_row = r_row;
        if (WW'(r_col) == r_width - WW'(1)) begin
            n_col = '0;
            if (HW'(r_row) == r_height - HW'(1)) begin
                n_row = '0;
            end else begin
                n_row = r_row + RW'(1);
            end
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_W;
            r_height <= RST_H;
            r_col    <= '0;
            r_row    <= '0;
            r_s1_blk <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (i_cfg_index == pix2avg_pkg::CFG_FRAME_WIDTH) begin
                    r_width <= n_width;
                end
                if (i_cfg_index == pix2avg_pkg::CFG_FRAME_HEIGHT) begin
                    r_height <= n_height;
                end
                if (cfg_hit) begin
                    r_col <= '0;
                    r_row <= '0;
                end
            end else if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (!o_stall) begin
                r_s1_blk <= rd_pair;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && !r_col[0]) begin
            r_left <= i_pixel;
        end
        if (!o_stall && rd_pair) begin
            r_s1_sum <= pair_sum;
            r_s1_row <= KW'(r_row);
            r_s1_col <= KW'(r_col);
            r_s1_eof <= eof;
        end
    end

    pix2avg_line_mem #(
        .DEPTH (LD),
        .AW    (AW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_pair),
        .i_wr_addr (line_addr),
        .i_wr_data (pair_sum),
        .i_rd_en   (rd_pair),
        .i_rd_addr (line_addr),
        .o_rd_data (above)
    );

    assign total     = {1'b0, above} + {1'b0, r_s1_sum};
    assign blk.value = total[SW:2];
    assign blk.row   = r_s1_row;
    assign blk.col   = r_s1_col;
    assign blk.eof   = r_s1_eof;
    assign push      = r_s1_blk && !q_full;

    pix2avg_blk_queue u_blk_queue (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_blk           (blk),
        .o_full          (q_full),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_value         (o_value),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_last_of_block (o_last_of_block),
        .o_end_of_frame  (o_end_of_frame)
    );

endmodule

// ----- sv/pix2avg_checker.sv -----
// ---------------------------------------------------------------------------
// pix2avg_checker
// Port-level checks on the result channel of the pixelator.
// ---------------------------------------------------------------------------
`include "pixelate_2x2_block_average_defines.svh"

module pix2avg_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [pix2avg_pkg::PIX_W-1:0]   o_value,
    input logic [pix2avg_pkg::COORD_W-1:0] o_out_row,
    input logic [pix2avg_pkg::COORD_W-1:0] o_out_col,
    input logic                            o_last_of_block,
    input logic                            o_end_of_frame
);

    `P2A_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_value) && $stable(o_out_row) && $stable(o_out_col) && $stable(o_last_of_block) && $stable(o_end_of_frame), "stalled result word changed")
    `P2A_ASSERT_IMPLY(a_last_corner, o_valid && o_last_of_block, o_out_row[0] && o_out_col[0], "block end not at odd row and odd column")
    `P2A_ASSERT_IMPLY(a_mid_not_corner, o_valid && !o_last_of_block, !(o_out_row[0] && o_out_col[0]), "odd corner word not flagged last")
    `P2A_ASSERT_IMPLY(a_eof_last, o_valid && o_end_of_frame, o_last_of_block, "frame end without block end")
    `P2A_ASSERT_NEXT(a_block_same_value, o_valid && !i_stall && !o_last_of_block, o_valid && $stable(o_value), "block words differ or break off")

endmodule

bind pixelate_2x2_block_average pix2avg_checker u_pix2avg_checker (.*);

// ----- tb/pix2avg_block_checker.sv -----
// ---------------------------------------------------------------------------
// pix2avg_block_checker
// Watches the config, pixel and result channels of the 2x2 block average
// pixelator. It keeps its own copy of the frame position, the pair-sum line
// and the size registers, and queues four words per finished block. Each
// result word taken is compared field by field with the oldest queued word.
// ---------------------------------------------------------------------------
module pix2avg_block_checker #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [pix2avg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pix2avg_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                              i_pix_valid,
    input  logic                              i_pix_stall,
    input  logic [pix2avg_pkg::PIX_W-1:0]     i_pixel,
    input  logic                              i_res_valid,
    input  logic                              i_res_stall,
    input  logic [pix2avg_pkg::PIX_W-1:0]     i_value,
    input  logic [pix2avg_pkg::COORD_W-1:0]   i_out_row,
    input  logic [pix2avg_pkg::COORD_W-1:0]   i_out_col,
    input  logic                              i_last_of_block,
    input  logic                              i_end_of_frame,
    output int                                o_fail_count,
    output int                                o_pending
);
    import pix2avg_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0]   value;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
        logic               eof;
    } avg_word_t;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      row_pos;
    int unsigned      col_pos;
    logic [PIX_W-1:0] left_px;
    logic [SUM_W-1:0] pair_line [MAX_WIDTH/2];
    avg_word_t        block_words [$];
    int               fail_cnt = 0;

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] raw,
                                              input int unsigned hi);
        if (raw < 2) return 2;
        if (raw > hi) return hi;
        return raw;
    endfunction

    task automatic push_word(input logic [PIX_W-1:0] avg, input int unsigned r,
                             input int unsigned c, input logic last, input logic eof);
        avg_word_t w;
        w.value = avg;
        w.row   = r[COORD_W-1:0];
        w.col   = c[COORD_W-1:0];
        w.last  = last;
        w.eof   = eof;
        block_words.push_back(w);
    endtask

    task automatic take_pixel(input logic [PIX_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned slot;
        int unsigned sum;
        int unsigned avg;
        logic        eof;
        w    = clamp_dim(width_reg, MAX_WIDTH);
        h    = clamp_dim(height_reg, MAX_HEIGHT);
        slot = col_pos / 2;
        if (col_pos % 2 == 0) begin
            left_px = px;
        end else if (row_pos % 2 == 0) begin
            sum = left_px + px;
            pair_line[slot] = sum[SUM_W-1:0];
        end else begin
            sum = pair_line[slot] + left_px + px;
            avg = sum >> 2;
            eof = (row_pos == (h & ~32'd1) - 1) && (col_pos == (w & ~32'd1) - 1);
            push_word(avg[PIX_W-1:0], row_pos - 1, col_pos - 1, 1'b0, 1'b0);
            push_word(avg[PIX_W-1:0], row_pos - 1, col_pos,     1'b0, 1'b0);
            push_word(avg[PIX_W-1:0], row_pos,     col_pos - 1, 1'b0, 1'b0);
            push_word(avg[PIX_W-1:0], row_pos,     col_pos,     1'b1, eof);
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endtask

    task automatic note_field(input string name, input logic [COORD_W-1:0] want,
                              input logic [COORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        avg_word_t want;
        if (!i_rst_n) begin
            width_reg  = CFG_W'(MAX_WIDTH);
            height_reg = CFG_W'(MAX_HEIGHT);
            row_pos    = 0;
            col_pos    = 0;
            left_px    = '0;
            block_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_FRAME_WIDTH) begin
                    width_reg = i_cfg_data;
                    row_pos   = 0;
                    col_pos   = 0;
                end else if (i_cfg_index == CFG_FRAME_HEIGHT) begin
                    height_reg = i_cfg_data;
                    row_pos    = 0;
                    col_pos    = 0;
                end
            end
            if (i_pix_valid && !i_pix_stall) begin
                take_pixel(i_pixel);
            end
            if (i_res_valid && !i_res_stall) begin
                if (block_words.size() == 0) begin
                    $display("%0t: result word with none pending, expected nothing actual %0d (%0d,%0d)",
                             $time, i_value, i_out_row, i_out_col);
                    fail_cnt++;
                end else begin
                    want = block_words.pop_front();
                    note_field("value", want.value, i_value);
                    note_field("out_row", want.row, i_out_row);
                    note_field("out_col", want.col, i_out_col);
                    note_field("last_of_block", want.last, i_last_of_block);
                    note_field("end_of_frame", want.eof, i_end_of_frame);
                end
            end
        end
        o_pending    <= block_words.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Stimulus for the 2x2 block average pixelator: clamped and odd frame sizes,
// spare register indexes, frame restart, a clamped tall frame, then random
// small frames with bursty input and a randomly stalling output.
// ---------------------------------------------------------------------------
module tb;
    import pix2avg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_WORDS = 100;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HALF,
        STALL_HEAVY
    } t_stall_mode;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic [PIX_W-1:0]     i_pixel     = '0;
    logic                 i_stall     = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_stall;
    logic                 o_valid;
    logic [PIX_W-1:0]     o_value;
    logic [COORD_W-1:0]   o_out_row;
    logic [COORD_W-1:0]   o_out_col;
    logic                 o_last_of_block;
    logic                 o_end_of_frame;
    int                   fail_count;
    int                   pending;
    t_stall_mode          stall_mode   = STALL_NONE;
    int                   stall_timer  = 0;
    int                   burst_left   = 0;
    int                   random_words = 0;

    pixelate_2x2_block_average dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pixel         (i_pixel),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_value         (o_value),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_last_of_block (o_last_of_block),
        .o_end_of_frame  (o_end_of_frame)
    );

    pix2avg_block_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_pix_valid     (i_valid),
        .i_pix_stall     (o_stall),
        .i_pixel         (i_pixel),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_value         (o_value),
        .i_out_row       (o_out_row),
        .i_out_col       (o_out_col),
        .i_last_of_block (o_last_of_block),
        .i_end_of_frame  (o_end_of_frame),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("pixelate_2x2_block_average test failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (stall_timer == 0) begin
            stall_mode  <= t_stall_mode'($urandom_range(0, 3));
            stall_timer <= $urandom_range(20, 80);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 2) == 0);
            STALL_HALF:  i_stall <= ($urandom_range(0, 1) == 0);
            default:     i_stall <= (stall_timer[2:0] != 3'd0);
        endcase
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_write(CFG_FRAME_WIDTH, w);
        cfg_write(CFG_FRAME_HEIGHT, h);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input logic [PIX_W-1:0] px);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0) begin
                // hold off until the output side has caught up
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end else if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_word($urandom_range(0, 255));
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int w_raw;
        int h_raw;
        int area;
        int count;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sizes below range clamp to 2x2; the second frame follows the wrap
        set_frame(10'd0, 10'd1);
        repeat (4) send_word(8'hFF);
        repeat (3) send_word(8'h00);
        send_word(8'h03);
        settle();

        // spare indexes must not move the frame position
        set_frame(10'd4, 10'd4);
        send_random(6);
        settle();
        cfg_write(CFG_SPARE_LO, 10'h3FF);
        cfg_write(CFG_SPARE_HI, 10'h000);
        i_cfg_valid <= 1'b0;
        send_random(2);
        settle();

        // restart mid-frame; trailing column and row make no words
        set_frame(10'd3, 10'd3);
        send_random(9);
        settle();

        // height above range clamps to the tallest frame
        set_frame(10'd2, 10'h3FF);
        send_random(8);
        settle();

        while (random_words < RANDOM_WORDS) begin
            w_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
            h_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
            area  = (w_raw < 2 ? 2 : w_raw) * (h_raw < 2 ? 2 : h_raw);
            count = area * $urandom_range(1, 2);
            if ($urandom_range(0, 1) == 0) count += $urandom_range(1, area - 1);
            if (count > RANDOM_WORDS - random_words) count = RANDOM_WORDS - random_words;
            set_frame(w_raw[CFG_W-1:0], h_raw[CFG_W-1:0]);
            send_random(count);
            settle();
            random_words += count;
        end

        if (fail_count == 0) begin
            $display("pixelate_2x2_block_average test passed");
        end else begin
            $display("pixelate_2x2_block_average test failed");
        end
        $finish;
    end

endmodule
